// ----- hw/rtl/bis_pkg.sv -----
// ----------------------------------------------------------------------------
// bis_pkg
// Shared constants and types for the bilinear image scaler.
// ----------------------------------------------------------------------------
package bis_pkg;

   localparam int DEF_MAX_WIDTH  = 256;
   localparam int DEF_MAX_HEIGHT = 256;

   localparam int CFG_W     = 9;   // size registers
   localparam int CSR_IDX_W = 3;
   localparam int STEP_W    = 57;  // 9.48 step
   localparam int POS_W     = 58;  // position accumulator
   localparam int FRAC_SH   = 48;  // fractional bits of the step
   localparam int T_SH      = 36;  // position to 10.12 coordinate
   localparam int T_W       = POS_W - T_SH;
   localparam int WF_W      = 12;  // blend weight bits
   localparam int WT_W      = 25;  // product weight, up to 1.0 in 1.24
   localparam int ACC_W     = 32;
   localparam int PROD_W    = 2 * WF_W;
   localparam int ROWB_W    = 2 * CFG_W;

   localparam logic [T_W-1:0]   HALF_PIXEL = T_W'(12'h800);
   localparam logic [WT_W-1:0]  ONE_WT     = WT_W'(32'h1000000);
   localparam logic [ACC_W:0]   ROUND_HALF = (ACC_W+1)'(32'h800000);

   localparam logic [CSR_IDX_W-1:0] CSR_SRC_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_HEIGHT = 3'd3;

   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_PULL = 1'b1;

   typedef struct packed {
      logic [WF_W-1:0]  frac;
      logic [CFG_W-1:0] first;
      logic [CFG_W-1:0] second;
   } coord_type;

endpackage

// ----- hw/rtl/bilinear_image_scaler.sv -----
// Load request: accepted with no result.
// Pull request: coordinate, multiply, weight, fetch and done steps to the result
//   register, then ready again; a new request can be taken while the result waits.
//   The first pull of a frame first runs the two bit-serial step divisions (57 bits each).
// Store reads go through the single read port, one neighbor per cycle.
// Reset is synchronous; sizes return to 256, the frame store keeps its data.
// ----------------------------------------------------------------------------
// bilinear_image_scaler
// Frame store plus a sequenced bilinear resampler with a shared multiplier.
// ----------------------------------------------------------------------------
module bilinear_image_scaler #(
   parameter int MAX_WIDTH  = bis_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = bis_pkg::DEF_MAX_HEIGHT
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic req_func,
   input  logic req_frame_start,
   input  logic [7:0] req_in_byte_0,
   input  logic [7:0] req_in_byte_1,
   input  logic [7:0] req_in_byte_2,
   input  logic [7:0] req_in_byte_3,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [7:0] rsp_dest_x,
   output logic [7:0] rsp_dest_y,
   output logic [7:0] rsp_byte_0,
   output logic [7:0] rsp_byte_1,
   output logic [7:0] rsp_byte_2,
   output logic [7:0] rsp_byte_3,
   output logic rsp_last_pixel,
   input  logic csr_write,
   input  logic [bis_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bis_pkg::CFG_W-1:0] csr_wdata
);

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = $clog2(DEPTH);
   localparam int LA_W  = AW + 1;
   localparam int CW    = bis_pkg::CFG_W;

   typedef enum logic [2:0] {
      ST_IDLE, ST_DIV, ST_COORD, ST_MUL, ST_WEIGHT, ST_FETCH, ST_DONE
   } st_type;

   st_type state_ff, state_in;
   logic [CW-1:0] src_w_ff, src_w_in, src_h_ff, src_h_in;
   logic [CW-1:0] dst_w_ff, dst_w_in, dst_h_ff, dst_h_in;
   logic [LA_W-1:0] load_addr_ff, load_addr_in;
   logic [CW-1:0] col_ff, col_in, row_ff, row_in;
   logic [bis_pkg::STEP_W-1:0] step_h_ff, step_h_in, step_v_ff, step_v_in;
   logic [bis_pkg::POS_W-1:0] pos_h_ff, pos_h_in, pos_v_ff, pos_v_in;
   logic ready_ff, ready_in;
   logic div_vert_ff, div_vert_in;
   logic [5:0] div_cnt_ff, div_cnt_in;
   logic [bis_pkg::STEP_W-1:0] div_num_ff, div_num_in, div_q_ff, div_q_in;
   logic [CW-1:0] div_rem_ff, div_rem_in;
   logic [CW-1:0] x1_ff, x1_in, x2_ff, x2_in, y1_ff, y1_in, y2_ff, y2_in;
   logic [bis_pkg::WF_W-1:0] fx_ff, fx_in, fy_ff, fy_in;
   logic [bis_pkg::PROD_W-1:0] fxy_ff, fxy_in;
   logic [bis_pkg::ROWB_W-1:0] base1_ff, base1_in, base2_ff, base2_in;
   logic [bis_pkg::WT_W-1:0] w_ff [4];
   logic [bis_pkg::WT_W-1:0] w_in [4];
   logic [bis_pkg::ACC_W-1:0] acc_ff [4];
   logic [bis_pkg::ACC_W-1:0] acc_in [4];
   logic [2:0] seq_cnt_ff, seq_cnt_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic [7:0] rsp_b_ff [4];
   logic [7:0] rsp_b_in [4];
   logic rsp_last_ff, rsp_last_in;

   logic [31:0] store [DEPTH];
   logic [31:0] rd_data_ff;
   logic [AW-1:0] rd_addr, mem_wa;
   logic mem_we;
   logic [31:0] mem_wd;

   logic [CW-1:0] sw_e, sh_e, dw_e, dh_e;
   logic copy_mode;
   logic [bis_pkg::ROWB_W-1:0] cap;
   logic req_fire;
   logic [LA_W-1:0] la_cur;
   logic ready_cur;
   logic [CW-1:0] div_d;
   logic [CW:0] div_trial, div_diff;
   logic div_ge;
   logic [CW-1:0] div_rem_next;
   logic [bis_pkg::STEP_W-1:0] div_q_next;
   bis_pkg::coord_type ch, cv;
   logic [bis_pkg::WF_W-1:0] mul_a, mul_b;
   logic [bis_pkg::PROD_W-1:0] mul_p;
   logic [1:0] nb_sel, fetch_idx;
   logic [bis_pkg::ROWB_W:0] rd_addr_wide;
   logic [bis_pkg::ACC_W:0] rounded [4];
   logic col_end, row_end;
   logic csr_hit;

   function automatic logic [CW-1:0] eff_size(input logic [CW-1:0] v, input int max_v);
      logic [CW-1:0] r;
      if (v == '0) r = CW'(1);
      else if (32'(v) > 32'(max_v)) r = CW'(max_v);
      else r = v;
      return r;
   endfunction

   function automatic bis_pkg::coord_type coord_of(input logic [bis_pkg::POS_W-1:0] pos,
                                                   input logic [CW-1:0] size);
      logic [bis_pkg::T_W-1:0] t;
      logic [bis_pkg::T_W-13:0] first_w;
      logic [CW-1:0] last_idx;
      logic [CW:0] next_idx;
      bis_pkg::coord_type c;
      t = pos[bis_pkg::POS_W-1:bis_pkg::T_SH];
      t = (t > bis_pkg::HALF_PIXEL) ? t - bis_pkg::HALF_PIXEL : '0;
      c.frac = t[bis_pkg::WF_W-1:0];
      first_w = t[bis_pkg::T_W-1:bis_pkg::WF_W];
      last_idx = size - CW'(1);
      c.first = (first_w > (bis_pkg::T_W-12)'(last_idx)) ? last_idx : CW'(first_w);
      next_idx = {1'b0, c.first} + (CW+1)'(1);
      c.second = (next_idx < {1'b0, size}) ? next_idx[CW-1:0] : last_idx;
      return c;
   endfunction

   assign sw_e = eff_size(src_w_ff, MAX_WIDTH);
   assign sh_e = eff_size(src_h_ff, MAX_HEIGHT);
   assign dw_e = eff_size(dst_w_ff, MAX_WIDTH);
   assign dh_e = eff_size(dst_h_ff, MAX_HEIGHT);
   assign copy_mode = (sw_e == dw_e) && (sh_e == dh_e);
   assign cap = sw_e * sh_e;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign la_cur    = req_frame_start ? '0 : load_addr_ff;
   assign ready_cur = req_frame_start ? 1'b0 : ready_ff;
   assign csr_hit   = csr_write && (csr_index == bis_pkg::CSR_SRC_WIDTH ||
                      csr_index == bis_pkg::CSR_SRC_HEIGHT ||
                      csr_index == bis_pkg::CSR_DST_WIDTH ||
                      csr_index == bis_pkg::CSR_DST_HEIGHT);

   // bit-serial restoring divider, one quotient bit per cycle
   assign div_d        = div_vert_ff ? dh_e : dw_e;
   assign div_trial    = {div_rem_ff, div_num_ff[bis_pkg::STEP_W-1]};
   assign div_ge       = div_trial >= {1'b0, div_d};
   assign div_diff     = div_trial - {1'b0, div_d};
   assign div_rem_next = div_ge ? div_diff[CW-1:0] : div_trial[CW-1:0];
   assign div_q_next   = {div_q_ff[bis_pkg::STEP_W-2:0], div_ge};

   assign ch = coord_of(pos_h_ff, sw_e);
   assign cv = coord_of(pos_v_ff, sh_e);

   // shared multiplier: weight product, then the two row bases
   always_comb begin
      case (seq_cnt_ff)
         3'd0: begin
            mul_a = fx_ff;
            mul_b = fy_ff;
         end
         3'd1: begin
            mul_a = bis_pkg::WF_W'(y1_ff);
            mul_b = bis_pkg::WF_W'(sw_e);
         end
         default: begin
            mul_a = bis_pkg::WF_W'(y2_ff);
            mul_b = bis_pkg::WF_W'(sw_e);
         end
      endcase
   end
   assign mul_p = mul_a * mul_b;

   assign fetch_idx = seq_cnt_ff[1:0];
   assign nb_sel    = 2'(seq_cnt_ff - 3'd1);
   assign rd_addr_wide = (bis_pkg::ROWB_W+1)'(fetch_idx[1] ? base2_ff : base1_ff)
                       + (bis_pkg::ROWB_W+1)'(fetch_idx[0] ? x2_ff : x1_ff);
   assign rd_addr = AW'(rd_addr_wide);

   assign col_end = ({1'b0, col_ff} + (CW+1)'(1)) >= {1'b0, dw_e};
   assign row_end = ({1'b0, row_ff} + (CW+1)'(1)) >= {1'b0, dh_e};

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         rounded[k] = (bis_pkg::ACC_W+1)'(acc_ff[k]) + bis_pkg::ROUND_HALF;
      end
   end

   always_comb begin
      state_in = state_ff;
      src_w_in = src_w_ff;
      src_h_in = src_h_ff;
      dst_w_in = dst_w_ff;
      dst_h_in = dst_h_ff;
      load_addr_in = load_addr_ff;
      col_in = col_ff;
      row_in = row_ff;
      step_h_in = step_h_ff;
      step_v_in = step_v_ff;
      pos_h_in = pos_h_ff;
      pos_v_in = pos_v_ff;
      ready_in = ready_ff;
      div_vert_in = div_vert_ff;
      div_cnt_in = div_cnt_ff;
      div_num_in = div_num_ff;
      div_q_in = div_q_ff;
      div_rem_in = div_rem_ff;
      x1_in = x1_ff;
      x2_in = x2_ff;
      y1_in = y1_ff;
      y2_in = y2_ff;
      fx_in = fx_ff;
      fy_in = fy_ff;
      fxy_in = fxy_ff;
      base1_in = base1_ff;
      base2_in = base2_ff;
      w_in = w_ff;
      acc_in = acc_ff;
      seq_cnt_in = seq_cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_x_in = rsp_x_ff;
      rsp_y_in = rsp_y_ff;
      rsp_b_in = rsp_b_ff;
      rsp_last_in = rsp_last_ff;
      mem_we = 1'b0;
      mem_wa = la_cur[AW-1:0];
      mem_wd = {req_in_byte_3, req_in_byte_2, req_in_byte_1, req_in_byte_0};

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_frame_start) begin
                  load_addr_in = '0;
                  col_in = '0;
                  row_in = '0;
                  ready_in = 1'b0;
               end
               if (req_func == bis_pkg::FUNC_LOAD) begin
                  // drop loads once the store holds a full source image
                  if (32'(la_cur) < 32'(cap)) begin
                     mem_we = 1'b1;
                     load_addr_in = la_cur + LA_W'(1);
                  end
               end else if (!ready_cur) begin
                  div_vert_in = 1'b0;
                  div_cnt_in = '0;
                  div_rem_in = '0;
                  div_q_in = '0;
                  div_num_in = {sw_e, bis_pkg::FRAC_SH'(0)};
                  state_in = ST_DIV;
               end else begin
                  state_in = ST_COORD;
               end
            end
         end
         ST_DIV: begin
            div_rem_in = div_rem_next;
            div_q_in = div_q_next;
            div_num_in = div_num_ff << 1;
            div_cnt_in = div_cnt_ff + 6'd1;
            if (div_cnt_ff == 6'(bis_pkg::STEP_W - 1)) begin
               div_cnt_in = '0;
               div_rem_in = '0;
               div_q_in = '0;
               if (!div_vert_ff) begin
                  step_h_in = div_q_next;
                  pos_h_in = bis_pkg::POS_W'(div_q_next >> 1) - bis_pkg::POS_W'(1);
                  div_vert_in = 1'b1;
                  div_num_in = {sh_e, bis_pkg::FRAC_SH'(0)};
               end else begin
                  step_v_in = div_q_next;
                  pos_v_in = bis_pkg::POS_W'(div_q_next >> 1) - bis_pkg::POS_W'(1);
                  ready_in = 1'b1;
                  state_in = ST_COORD;
               end
            end
         end
         ST_COORD: begin
            x2_in = ch.second;
            y2_in = cv.second;
            if (copy_mode) begin
               // weights of zero give the stored pixel back exactly
               x1_in = col_ff;
               y1_in = row_ff;
               fx_in = '0;
               fy_in = '0;
            end else begin
               x1_in = ch.first;
               y1_in = cv.first;
               fx_in = ch.frac;
               fy_in = cv.frac;
            end
            seq_cnt_in = '0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            case (seq_cnt_ff)
               3'd0: fxy_in = mul_p;
               3'd1: base1_in = mul_p[bis_pkg::ROWB_W-1:0];
               default: base2_in = mul_p[bis_pkg::ROWB_W-1:0];
            endcase
            seq_cnt_in = seq_cnt_ff + 3'd1;
            if (seq_cnt_ff == 3'd2) begin
               state_in = ST_WEIGHT;
            end
         end
         ST_WEIGHT: begin
            w_in[0] = bis_pkg::ONE_WT - bis_pkg::WT_W'({fx_ff, 12'd0})
                    - bis_pkg::WT_W'({fy_ff, 12'd0}) + bis_pkg::WT_W'(fxy_ff);
            w_in[1] = bis_pkg::WT_W'({fx_ff, 12'd0}) - bis_pkg::WT_W'(fxy_ff);
            w_in[2] = bis_pkg::WT_W'({fy_ff, 12'd0}) - bis_pkg::WT_W'(fxy_ff);
            w_in[3] = bis_pkg::WT_W'(fxy_ff);
            for (int k = 0; k < 4; k++) begin
               acc_in[k] = '0;
            end
            seq_cnt_in = '0;
            state_in = ST_FETCH;
         end
         ST_FETCH: begin
            // read data is registered and arrives in the cycle after its address
            if (seq_cnt_ff != 3'd0) begin
               for (int k = 0; k < 4; k++) begin
                  acc_in[k] = acc_ff[k] + bis_pkg::ACC_W'(
                     (bis_pkg::ACC_W+1)'(rd_data_ff[8*k +: 8])
                     * (bis_pkg::ACC_W+1)'(w_ff[nb_sel]));
               end
            end
            seq_cnt_in = seq_cnt_ff + 3'd1;
            if (seq_cnt_ff == 3'd4) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_x_in = col_ff[7:0];
               rsp_y_in = 8'(dh_e - CW'(1) - row_ff);
               for (int k = 0; k < 4; k++) begin
                  rsp_b_in[k] = rounded[k][31:24];
               end
               rsp_last_in = col_end && row_end;
               if (col_end) begin
                  col_in = '0;
                  pos_h_in = bis_pkg::POS_W'(step_h_ff >> 1) - bis_pkg::POS_W'(1);
                  if (row_end) begin
                     row_in = '0;
                     ready_in = 1'b0;
                  end else begin
                     row_in = row_ff + CW'(1);
                     pos_v_in = pos_v_ff + bis_pkg::POS_W'(step_v_ff);
                  end
               end else begin
                  col_in = col_ff + CW'(1);
                  pos_h_in = pos_h_ff + bis_pkg::POS_W'(step_h_ff);
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (csr_hit) begin
         unique case (csr_index)
            bis_pkg::CSR_SRC_WIDTH:  src_w_in = csr_wdata;
            bis_pkg::CSR_SRC_HEIGHT: src_h_in = csr_wdata;
            bis_pkg::CSR_DST_WIDTH:  dst_w_in = csr_wdata;
            default:                 dst_h_in = csr_wdata;
         endcase
         col_in = '0;
         row_in = '0;
         ready_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         src_w_ff <= CW'(256);
         src_h_ff <= CW'(256);
         dst_w_ff <= CW'(256);
         dst_h_ff <= CW'(256);
         load_addr_ff <= '0;
         col_ff <= '0;
         row_ff <= '0;
         step_h_ff <= '0;
         step_v_ff <= '0;
         pos_h_ff <= '0;
         pos_v_ff <= '0;
         ready_ff <= 1'b0;
         div_vert_ff <= 1'b0;
         div_cnt_ff <= '0;
         seq_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         src_w_ff <= src_w_in;
         src_h_ff <= src_h_in;
         dst_w_ff <= dst_w_in;
         dst_h_ff <= dst_h_in;
         load_addr_ff <= load_addr_in;
         col_ff <= col_in;
         row_ff <= row_in;
         step_h_ff <= step_h_in;
         step_v_ff <= step_v_in;
         pos_h_ff <= pos_h_in;
         pos_v_ff <= pos_v_in;
         ready_ff <= ready_in;
         div_vert_ff <= div_vert_in;
         div_cnt_ff <= div_cnt_in;
         seq_cnt_ff <= seq_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      div_num_ff <= div_num_in;
      div_q_ff <= div_q_in;
      div_rem_ff <= div_rem_in;
      x1_ff <= x1_in;
      x2_ff <= x2_in;
      y1_ff <= y1_in;
      y2_ff <= y2_in;
      fx_ff <= fx_in;
      fy_ff <= fy_in;
      fxy_ff <= fxy_in;
      base1_ff <= base1_in;
      base2_ff <= base2_in;
      w_ff <= w_in;
      acc_ff <= acc_in;
      rsp_x_ff <= rsp_x_in;
      rsp_y_ff <= rsp_y_in;
      rsp_b_ff <= rsp_b_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store[mem_wa] <= mem_wd;
      end
      rd_data_ff <= store[rd_addr];
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_dest_x     = rsp_x_ff;
   assign rsp_dest_y     = rsp_y_ff;
   assign rsp_byte_0     = rsp_b_ff[0];
   assign rsp_byte_1     = rsp_b_ff[1];
   assign rsp_byte_2     = rsp_b_ff[2];
   assign rsp_byte_3     = rsp_b_ff[3];
   assign rsp_last_pixel = rsp_last_ff;

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result appeared outside the done step");

   a_steps_ready: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_COORD |-> ready_ff)
      else $error("coordinates taken before the steps were computed");

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      col_ff < dw_e && row_ff < dh_e)
      else $error("output position outside the destination");

   a_load_range: assert property (@(posedge clock) disable iff (reset)
      32'(load_addr_ff) <= 32'(DEPTH))
      else $error("load address beyond the frame store");

endmodule
